FILE: hw/rtl/fpr_pkg.sv
package fpr_pkg;

  localparam int FrameCount = 4;
  localparam int FrameIdxW  = (FrameCount > 1) ? $clog2(FrameCount) : 1;
  localparam int PageW      = 16;
  localparam int FrameW     = 2;
  localparam int CountW     = 32;

  // priority flags handed down the row of cells
  typedef struct packed {
    logic hit_seen;
    logic free_seen;
  } fpr_chain_t;

  // what each cell reports to the top level
  typedef struct packed {
    logic hit_sel;
    logic load;
    logic token;
  } fpr_cell_stat_t;

endpackage

FILE: hw/rtl/fpr_cell.sv
module fpr_cell
  import fpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_i,
  input  logic                 token_rst_i,
  input  logic [PageW-1:0]     page_i,
  input  fpr_chain_t           chain_i,
  input  logic                 any_hit_i,
  input  logic                 any_free_i,
  input  logic                 token_prev_i,
  output fpr_chain_t           chain_o,
  output fpr_cell_stat_t       stat_o,
  output logic [PageW-1:0]     page_o
);

  logic             valid_q, valid_d;
  logic [PageW-1:0] page_q;
  logic             token_q, token_d;
  logic             my_hit, my_free, sel_free, load;

  assign my_hit   = valid_q && (page_q == page_i);
  assign my_free  = !valid_q;
  assign sel_free = my_free && !chain_i.free_seen;

  // victim is the lowest free frame, else the cell that holds the oldest-load token
  assign load = req_i && !any_hit_i && (any_free_i ? sel_free : token_q);

  assign chain_o.hit_seen  = chain_i.hit_seen || my_hit;
  assign chain_o.free_seen = chain_i.free_seen || my_free;

  assign stat_o.hit_sel = my_hit && !chain_i.hit_seen;
  assign stat_o.load    = load;
  assign stat_o.token   = token_q;
  assign page_o         = page_q;

  assign valid_d = valid_q || load;
  // pass the token on to the next cell on every eviction
  assign token_d = (req_i && !any_hit_i && !any_free_i) ? token_prev_i : token_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      token_q <= token_rst_i;
    end else begin
      valid_q <= valid_d;
      token_q <= token_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      page_q <= page_i;
    end
  end

endmodule

FILE: hw/rtl/fpr_sat_cnt.sv
module fpr_sat_cnt
  import fpr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              inc_i,
  output logic [CountW-1:0] count_o
);

  logic [CountW-1:0] count_q, count_d;

  // hold at all ones
  assign count_d = (inc_i && (count_q != {CountW{1'b1}})) ? count_q + 1'b1 : count_q;
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

FILE: hw/rtl/fifo_page_replacement.sv
// Channel   Direction  Handshake           Payload
// command   in         start / busy        page_i
// result    out        done_o (strobe)     hit_o, frame_o, evicted_valid_o, victim_page_o,
//                                          hit_total_o, fault_total_o
//
// One item per cycle: the result strobes in the cycle after start is taken.
// The figure is set by the compare and priority chain through the frame cells,
// all of which is combinational; busy stays low.
// Reset empties every frame and clears both counters; the oldest-load token sits in frame 0.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fifo_page_replacement
  import fpr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [PageW-1:0]  page_i,
  output logic              done_o,
  output logic              hit_o,
  output logic [FrameW-1:0] frame_o,
  output logic              evicted_valid_o,
  output logic [PageW-1:0]  victim_page_o,
  output logic [CountW-1:0] hit_total_o,
  output logic [CountW-1:0] fault_total_o
);

  logic                 req;
  fpr_chain_t           chain [FrameCount+1];
  fpr_cell_stat_t       stat  [FrameCount];
  logic [PageW-1:0]     cell_page [FrameCount];
  logic [FrameCount-1:0] tokens;
  logic                 any_hit, any_free;
  logic [FrameIdxW-1:0] frame_idx;
  logic [PageW-1:0]     ev_page;

  logic                 done_q;
  logic                 hit_q;
  logic [FrameW-1:0]    frame_q;
  logic                 ev_valid_q;
  logic [PageW-1:0]     ev_page_q;

  assign busy = 1'b0;
  assign req  = start && !busy;

  assign chain[0] = '0;
  assign any_hit  = chain[FrameCount].hit_seen;
  assign any_free = chain[FrameCount].free_seen;

  for (genvar g = 0; g < FrameCount; g++) begin : g_cell
    localparam int Prev = (g + FrameCount - 1) % FrameCount;
    fpr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .req_i        (req),
      .token_rst_i  ((g == 0) ? 1'b1 : 1'b0),
      .page_i       (page_i),
      .chain_i      (chain[g]),
      .any_hit_i    (any_hit),
      .any_free_i   (any_free),
      .token_prev_i (tokens[Prev]),
      .chain_o      (chain[g+1]),
      .stat_o       (stat[g]),
      .page_o       (cell_page[g])
    );
    assign tokens[g] = stat[g].token;
  end

  // encode the selected frame and pick out the page being evicted
  always_comb begin
    frame_idx = '0;
    ev_page   = '0;
    for (int i = 0; i < FrameCount; i++) begin
      if (any_hit ? stat[i].hit_sel : stat[i].load) begin
        frame_idx = frame_idx | FrameIdxW'(i);
      end
      if (stat[i].load && !any_free) begin
        ev_page = ev_page | cell_page[i];
      end
    end
  end

  fpr_sat_cnt u_hits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .inc_i   (req && any_hit),
    .count_o (hit_total_o)
  );

  fpr_sat_cnt u_faults (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .inc_i   (req && !any_hit),
    .count_o (fault_total_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req) begin
      hit_q      <= any_hit;
      frame_q    <= FrameW'(frame_idx);
      ev_valid_q <= !any_hit && !any_free;
      ev_page_q  <= ev_page;
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign frame_o         = frame_q;
  assign evicted_valid_o = ev_valid_q;
  assign victim_page_o   = ev_page_q;

`ifndef SYNTH
  a_done_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |=> done_o) else $error("item taken without result strobe");

  a_evict_only_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_valid_o |-> !hit_o) else $error("eviction reported on a hit");

  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(tokens)) else $error("oldest-load token lost or duplicated");

  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req && !any_hit |=> $countones(tokens) == 1 && done_o && !hit_o)
    else $error("fault did not complete cleanly");
`endif

endmodule
